[sv/fbpa_pkg.sv]
// Shared widths, reset values and codes of the fixed block pool allocator.
package fbpa_pkg;

    localparam int unsigned ADDR_IO_W       = 32;
    localparam int unsigned SIZE_W          = 17;
    localparam int unsigned CNT_CFG_W       = 9;
    localparam int unsigned STATUS_W        = 3;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 32;

    localparam int unsigned DEF_MAX_BLOCKS  = 256;
    localparam int unsigned DEF_ADDR_WIDTH  = 32;

    localparam logic [ADDR_IO_W-1:0] RST_POOL_BASE   = 32'd0;
    localparam logic [SIZE_W-1:0]    RST_BLK_BYTES   = 17'd64;
    localparam logic [CNT_CFG_W-1:0] RST_BLOCK_COUNT = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_OOM     = 3'd1,
        ST_OUTSIDE = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_BLK_BYTES   = 2'd1,
        CFG_BLOCK_COUNT = 2'd2
    } t_cfg_idx;

endpackage

[sv/fbpa_req_if.sv]
// Request channel: allocate or free transaction towards the allocator.
interface fbpa_req_if;
    import fbpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_IO_W-1:0] free_addr;

    modport source (output valid, output kind, output free_addr, input ready);
    modport sink   (input valid, input kind, input free_addr, output ready);
endinterface

[sv/fbpa_rsp_if.sv]
// Response channel: one result transaction per request.
interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_IO_W-1:0] alloc_addr;
    t_status              status;
    logic [CNT_CFG_W-1:0] free_left;

    modport source (output valid, output alloc_addr, output status, output free_left,
                    input ready);
    modport sink   (input valid, input alloc_addr, input status, input free_left,
                    output ready);
endinterface

[sv/fbpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/fixed_block_pool_allocator.sv]
// Fixed block pool allocator: free-index stack and allocated map in RAM.
//
//  channel   | direction | transaction
//  ----------+-----------+----------------------------------------------
//  i_req     | in        | kind (0 allocate, 1 free), free_addr
//  o_rsp     | out       | alloc_addr, status, free_left
//  i_cfg_*   | in        | register write: pool_base, block bytes, block_count
//
// Allocate answers after stack read, index times size and add; out of memory answers
// straight from the request, a free outside the pool after the range check. Any other
// free runs a restoring divide, one index bit per cycle, then map read.
// After reset a clearing pass sweeps every map entry, i_req held off.
// One request is in flight at a time; a held result in the output register does
// not stop the next request from being accepted.
module fixed_block_pool_allocator #(
    parameter int unsigned MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
    parameter int unsigned ADDR_WIDTH = fbpa_pkg::DEF_ADDR_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fbpa_req_if.sink                        i_req,
    fbpa_rsp_if.source                      o_rsp
);
    import fbpa_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned AW     = ADDR_WIDTH;
    localparam int unsigned SPW    = SIZE_W + CNT_W;
    localparam int unsigned RW     = (AW > SPW) ? AW : SPW;
    localparam int unsigned PRD_W  = IDX_W + SIZE_W;
    localparam int unsigned STEP_W = $clog2(IDX_W + 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b0_0000_0001,
        S_IDLE  = 9'b0_0000_0010,
        S_POP   = 9'b0_0000_0100,
        S_ADDR  = 9'b0_0000_1000,
        S_CHK   = 9'b0_0001_0000,
        S_DIV   = 9'b0_0010_0000,
        S_MRD   = 9'b0_0100_0000,
        S_MAP   = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    // saturate a block count to the pool capacity
    function automatic logic [CNT_W-1:0] f_eff_count(input logic [CNT_CFG_W-1:0] c);
        logic [CNT_W-1:0] res;
        if (32'(c) > 32'(MAX_BLOCKS)) begin
            res = CNT_W'(MAX_BLOCKS);
        end else begin
            res = CNT_W'(c);
        end
        return res;
    endfunction

    t_state                r_state, n_state;
    logic [ADDR_IO_W-1:0]  r_pool_base, n_pool_base;
    logic [SIZE_W-1:0]     r_blk_bytes, n_blk_bytes;
    logic [CNT_CFG_W-1:0]  r_block_count, n_block_count;
    logic [CNT_W-1:0]      r_total, n_total;
    logic [CNT_W-1:0]      r_low, n_low;
    logic [IDX_W-1:0]      r_clr, n_clr;
    logic [RW-1:0]         r_rem, n_rem;
    logic [RW-1:0]         r_dvs, n_dvs;
    logic [SPW-1:0]        r_span, n_span;
    logic [IDX_W-1:0]      r_quo, n_quo;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [PRD_W-1:0]      r_prod, n_prod;
    logic [ADDR_IO_W-1:0]  r_res_addr, n_res_addr;
    t_status               r_res_status, n_res_status;
    logic                  r_ovld, n_ovld;
    logic [ADDR_IO_W-1:0]  r_o_addr, n_o_addr;
    t_status               r_o_status, n_o_status;
    logic [CNT_CFG_W-1:0]  r_o_left, n_o_left;

    logic [SIZE_W-1:0]     eff_size;
    logic [CNT_W-1:0]      eff_count;
    logic [CNT_W-1:0]      pos_pop;
    logic [AW-1:0]         free_off;
    logic [AW-1:0]         addr_sum;
    logic [IDX_W-1:0]      pop_idx;
    logic                  div_ge;
    logic                  req_acc;
    logic                  out_free;

    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr;
    logic [IDX_W-1:0]      stk_wdata;
    logic [IDX_W-1:0]      stk_rdata;
    logic                  map_we;
    logic [IDX_W-1:0]      map_waddr;
    logic                  map_wdata;
    logic                  map_rdata;

    // free-index stack and allocated-block map
    fbpa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (pos_pop[IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    fbpa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (r_quo),
        .o_rdata (map_rdata)
    );

    // effective configuration and derived terms
    assign eff_size  = (r_blk_bytes == '0) ? SIZE_W'(1) : r_blk_bytes;
    assign eff_count = f_eff_count(r_block_count);
    assign pos_pop   = r_total - CNT_W'(1);
    assign free_off  = AW'(i_req.free_addr) - AW'(r_pool_base);
    assign addr_sum  = AW'(r_pool_base) + AW'(r_prod);
    // positions below the low-water mark were never rewritten since the refill
    assign pop_idx   = (pos_pop < r_low) ? pos_pop[IDX_W-1:0] : stk_rdata;
    assign div_ge    = (r_rem >= r_dvs);
    assign req_acc   = i_req.valid && i_req.ready;
    assign out_free  = !r_ovld || o_rsp.ready;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_ovld;
    assign o_rsp.alloc_addr = r_o_addr;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.free_left  = r_o_left;

    // sequencer and next-state logic
    always_comb begin
        n_state       = r_state;
        n_pool_base   = r_pool_base;
        n_blk_bytes   = r_blk_bytes;
        n_block_count = r_block_count;
        n_total       = r_total;
        n_low         = r_low;
        n_clr         = r_clr;
        n_rem         = r_rem;
        n_dvs         = r_dvs;
        n_span        = r_span;
        n_quo         = r_quo;
        n_step        = r_step;
        n_prod        = r_prod;
        n_res_addr    = r_res_addr;
        n_res_status  = r_res_status;
        n_ovld        = r_ovld && !o_rsp.ready;
        n_o_addr      = r_o_addr;
        n_o_status    = r_o_status;
        n_o_left      = r_o_left;
        stk_we        = 1'b0;
        stk_waddr     = r_total[IDX_W-1:0];
        stk_wdata     = r_quo;
        map_we        = 1'b0;
        map_waddr     = r_quo;
        map_wdata     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // sweep the map to all clear
                map_we    = 1'b1;
                map_waddr = r_clr;
                n_clr     = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(MAX_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    if (!i_req.kind) begin
                        if (r_total == '0) begin
                            n_res_addr   = '0;
                            n_res_status = ST_OOM;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_POP;
                        end
                    end else begin
                        n_rem   = RW'(free_off);
                        n_span  = SPW'(eff_size) * SPW'(eff_count);
                        n_state = S_CHK;
                    end
                end
            end
            S_POP: begin
                // pop the index, mark it allocated, form the offset
                map_we    = 1'b1;
                map_waddr = pop_idx;
                map_wdata = 1'b1;
                n_quo     = pop_idx;
                n_prod    = PRD_W'(pop_idx) * PRD_W'(eff_size);
                n_total   = pos_pop;
                if (pos_pop < r_low) begin
                    n_low = pos_pop;
                end
                n_state   = S_ADDR;
            end
            S_ADDR: begin
                n_res_addr   = ADDR_IO_W'(addr_sum);
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_CHK: begin
                if (r_rem >= RW'(r_span)) begin
                    n_res_addr   = '0;
                    n_res_status = ST_OUTSIDE;
                    n_state      = S_DONE;
                end else begin
                    n_dvs   = RW'(eff_size) << (IDX_W - 1);
                    n_quo   = '0;
                    n_step  = STEP_W'(IDX_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle
                if (div_ge) begin
                    n_rem = r_rem - r_dvs;
                end
                n_quo = (r_quo << 1) | IDX_W'(div_ge);
                n_dvs = r_dvs >> 1;
                if (r_step == '0) begin
                    n_state = S_MRD;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_MRD: begin
                n_state = S_MAP;
            end
            S_MAP: begin
                n_res_addr = '0;
                if (!map_rdata) begin
                    n_res_status = ST_DOUBLE;
                end else begin
                    map_we = 1'b1;
                    if (r_total < eff_count) begin
                        stk_we       = 1'b1;
                        n_total      = r_total + CNT_W'(1);
                        n_res_status = ST_OK;
                    end else begin
                        n_res_status = ST_FULL;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hand over to the output register once it is free
                if (out_free) begin
                    n_ovld     = 1'b1;
                    n_o_addr   = r_res_addr;
                    n_o_status = r_res_status;
                    n_o_left   = CNT_CFG_W'(r_total);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register writes; a count write refills the stack
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POOL_BASE: begin
                    n_pool_base = ADDR_IO_W'(i_cfg_data);
                end
                CFG_BLK_BYTES: begin
                    n_blk_bytes = i_cfg_data[SIZE_W-1:0];
                end
                CFG_BLOCK_COUNT: begin
                    n_block_count = i_cfg_data[CNT_CFG_W-1:0];
                    n_total       = f_eff_count(i_cfg_data[CNT_CFG_W-1:0]);
                    n_low         = f_eff_count(i_cfg_data[CNT_CFG_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_pool_base   <= RST_POOL_BASE;
            r_blk_bytes   <= RST_BLK_BYTES;
            r_block_count <= RST_BLOCK_COUNT;
            r_total       <= f_eff_count(RST_BLOCK_COUNT);
            r_low         <= f_eff_count(RST_BLOCK_COUNT);
            r_clr         <= '0;
            r_ovld        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pool_base   <= n_pool_base;
            r_blk_bytes   <= n_blk_bytes;
            r_block_count <= n_block_count;
            r_total       <= n_total;
            r_low         <= n_low;
            r_clr         <= n_clr;
            r_ovld        <= n_ovld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_dvs        <= n_dvs;
        r_span       <= n_span;
        r_quo        <= n_quo;
        r_step       <= n_step;
        r_prod       <= n_prod;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_o_addr     <= n_o_addr;
        r_o_status   <= n_o_status;
        r_o_left     <= n_o_left;
    end
endmodule
